// ===== rtl/core/rate_limited_release_queue_defines.svh =====
// assertion macros for the release queue
`ifndef RATE_LIMITED_RELEASE_QUEUE_DEFINES_SVH
`define RATE_LIMITED_RELEASE_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RLRQ_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("release queue check failed");
`define RLRQ_ASSERT_IMPLIES(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("release queue check failed");
`define RLRQ_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("release queue check failed");
`else
`define RLRQ_ASSERT_NEVER(label, cond)
`define RLRQ_ASSERT_IMPLIES(label, a, b)
`define RLRQ_ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== rtl/core/rlrq_pkg.sv =====
// shared constants and types of the release queue
package rlrq_pkg;
   localparam int QUEUE_DEPTH = 32;
   localparam int TAG_BITS = 16;
   localparam int TASK_BITS = 8;
   localparam int MAX_RESULTS = 32;
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int QUOTA_BITS = 6;
   localparam int ENTRY_BITS = TAG_BITS + TASK_BITS;

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_TICK = 2'd2,
      REQ_SHUTDOWN = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_RELEASED = 2'd1,
      KIND_CANCELED = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_SUCCESS = 2'd0,
      ST_SHUTTING_DOWN = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_QUEUE_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_LIMITED = 2'd0,
      MODE_IDLE = 2'd1,
      MODE_SHUTDOWN = 2'd2
   } mode_type;

   localparam logic [1:0] CSR_PER_TICK = 2'd0;
   localparam logic [1:0] CSR_LIFO_MODE = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;
endpackage

// ===== rtl/core/rlrq_ram.sv =====
// generic single-write, single-read ram with registered read
module rlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== rtl/core/rate_limited_release_queue.sv =====
// rate limited release queue: circular buffer in ram and sequencing fsm
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser: req_type; tdata: event_tag, dest_task
//  rsp     | out | rsp_tvalid/tready    | tuser: result_kind; tdata: status, tag, task;
//          |     |                      | tlast: last
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// enqueue passes exec then reply, a tick without release exec alone; each released or
// canceled entry goes through a ram read then the result register, over the one read port
// dequeue scans each entry by read then compare, and moves each tail entry by read then write
// reset is synchronous; queue contents are kept, head, count, mode, ticks and state cleared
// a stalled rsp side holds the fsm; a new request is taken once the last result is loaded
`include "rate_limited_release_queue_defines.svh"
module rate_limited_release_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [23:0] req_tdata,   // [15:0] event_tag, [23:16] dest_task
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic [31:0] rsp_tdata,   // [1:0] status, [17:2] out_tag, [25:18] out_task
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rlrq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SCAN_RD, S_SCAN_CMP, S_SH_RD, S_SH_WR, S_POP_RD, S_POP_OUT, S_REPLY
   } state_type;

   state_type              state_ff, state_in;
   logic [PTR_BITS-1:0]    head_ff, head_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   mode_type               mode_ff, mode_in;
   logic [15:0]            ticks_ff, ticks_in;
   logic [QUOTA_BITS-1:0]  per_tick_ff;
   logic                   lifo_ff;
   logic [15:0]            interval_ff;
   req_kind_type           req_ff, req_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [TASK_BITS-1:0]   task_ff, task_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [QUOTA_BITS-1:0]  quota_ff, quota_in;
   logic [QUOTA_BITS-1:0]  nout_ff, nout_in;
   status_type             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_kind_type        rsp_kind_ff, rsp_kind_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [TASK_BITS-1:0]   rsp_task_ff, rsp_task_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_we, ram_re;
   logic [PTR_BITS-1:0]    ram_waddr, ram_raddr;
   logic [ENTRY_BITS-1:0]  ram_wdata, ram_rdata;
   logic [TAG_BITS-1:0]    rd_tag;
   logic [TASK_BITS-1:0]   rd_task;
   logic                   emit_ok;
   logic [QUOTA_BITS-1:0]  quota_clamped;

   assign rd_tag  = ram_rdata[TAG_BITS-1:0];
   assign rd_task = ram_rdata[ENTRY_BITS-1:TAG_BITS];
   assign emit_ok = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // quota out of range is pulled into 1..max
   always_comb begin
      if (per_tick_ff == '0) begin
         quota_clamped = QUOTA_BITS'(1);
      end else if (per_tick_ff > QUOTA_BITS'(MAX_RESULTS)) begin
         quota_clamped = QUOTA_BITS'(MAX_RESULTS);
      end else begin
         quota_clamped = per_tick_ff;
      end
   end

   rlrq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      count_in = count_ff;
      mode_in = mode_ff;
      ticks_in = ticks_ff;
      req_in = req_ff;
      tag_in = tag_ff;
      task_in = task_ff;
      idx_in = idx_ff;
      quota_in = quota_ff;
      nout_in = nout_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_task_in = rsp_task_ff;
      rsp_last_in = rsp_last_ff;
      ram_we = 1'b0;
      ram_waddr = head_ff + idx_ff[PTR_BITS-1:0];
      ram_wdata = ram_rdata;
      ram_re = 1'b0;
      ram_raddr = head_ff + idx_ff[PTR_BITS-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in = req_kind_type'(req_tuser);
               tag_in = req_tdata[TAG_BITS-1:0];
               task_in = req_tdata[ENTRY_BITS-1:TAG_BITS];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (req_ff)
               REQ_ENQUEUE: begin
                  state_in = S_REPLY;
                  if (mode_ff == MODE_SHUTDOWN) begin
                     status_in = ST_SHUTTING_DOWN;
                  end else if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                     status_in = ST_QUEUE_FULL;
                  end else begin
                     status_in = ST_SUCCESS;
                     ram_we = 1'b1;
                     ram_wdata = {task_ff, tag_ff};
                     if (lifo_ff) begin
                        ram_waddr = head_ff - 1'b1;
                        head_in = head_ff - 1'b1;
                     end else begin
                        ram_waddr = head_ff + count_ff[PTR_BITS-1:0];
                     end
                     count_in = count_ff + 1'b1;
                     if (mode_ff == MODE_IDLE) begin
                        mode_in = MODE_LIMITED;
                        ticks_in = '0;
                     end
                  end
               end
               REQ_DEQUEUE: begin
                  idx_in = '0;
                  if (count_ff == '0) begin
                     status_in = ST_NOT_FOUND;
                     state_in = S_REPLY;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               REQ_TICK: begin
                  state_in = S_IDLE;
                  quota_in = quota_clamped;
                  if (mode_ff == MODE_LIMITED) begin
                     if (ticks_ff != '0) begin
                        ticks_in = ticks_ff - 1'b1;
                     end else if (count_ff == '0) begin
                        mode_in = MODE_IDLE;
                     end else begin
                        state_in = S_POP_RD;
                     end
                  end
               end
               REQ_SHUTDOWN: begin
                  mode_in = MODE_SHUTDOWN;
                  ticks_in = '0;
                  nout_in = '0;
                  if (count_ff == '0) begin
                     status_in = (mode_ff != MODE_SHUTDOWN) ? ST_SUCCESS : ST_SHUTTING_DOWN;
                     state_in = S_REPLY;
                  end else begin
                     state_in = S_POP_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         // tag search, one entry per read
         S_SCAN_RD: begin
            ram_re = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (rd_tag == tag_ff) begin
               if (CNT_BITS'(idx_ff + 1'b1) == count_ff) begin
                  count_in = count_ff - 1'b1;
                  status_in = ST_SUCCESS;
                  state_in = S_REPLY;
               end else begin
                  state_in = S_SH_RD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               if (CNT_BITS'(idx_ff + 1'b1) == count_ff) begin
                  status_in = ST_NOT_FOUND;
                  state_in = S_REPLY;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         // close the gap: move entry idx+1 down to idx
         S_SH_RD: begin
            ram_re = 1'b1;
            ram_raddr = head_ff + idx_ff[PTR_BITS-1:0] + 1'b1;
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (CNT_BITS'(idx_ff + 2'd2) == count_ff) begin
               count_in = count_ff - 1'b1;
               status_in = ST_SUCCESS;
               state_in = S_REPLY;
            end else begin
               state_in = S_SH_RD;
            end
         end
         // release or cancel from the head
         S_POP_RD: begin
            ram_re = 1'b1;
            ram_raddr = head_ff;
            state_in = S_POP_OUT;
         end
         S_POP_OUT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_SUCCESS;
               rsp_tag_in = rd_tag;
               rsp_task_in = rd_task;
               head_in = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               if (req_ff == REQ_TICK) begin
                  rsp_kind_in = KIND_RELEASED;
                  quota_in = quota_ff - 1'b1;
                  rsp_last_in = (quota_ff == QUOTA_BITS'(1)) || (count_ff == CNT_BITS'(1));
                  if (quota_ff == QUOTA_BITS'(1)) begin
                     ticks_in = interval_ff;
                     state_in = S_IDLE;
                  end else if (count_ff == CNT_BITS'(1)) begin
                     mode_in = MODE_IDLE;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_POP_RD;
                  end
               end else begin
                  rsp_kind_in = KIND_CANCELED;
                  nout_in = nout_ff + 1'b1;
                  rsp_last_in = (count_ff == CNT_BITS'(1)) ||
                                (nout_ff == QUOTA_BITS'(MAX_RESULTS - 1));
                  state_in = rsp_last_in ? S_IDLE : S_POP_RD;
               end
            end
         end
         S_REPLY: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_STATUS;
               rsp_status_in = status_ff;
               rsp_tag_in = '0;
               rsp_task_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         mode_ff <= MODE_IDLE;
         ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         mode_ff <= mode_in;
         ticks_ff <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      tag_ff <= tag_in;
      task_ff <= task_in;
      idx_ff <= idx_in;
      quota_ff <= quota_in;
      nout_ff <= nout_in;
      status_ff <= status_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_task_ff <= rsp_task_in;
      rsp_last_ff <= rsp_last_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         per_tick_ff <= QUOTA_BITS'(1);
         lifo_ff <= 1'b0;
         interval_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_PER_TICK) begin
            per_tick_ff <= csr_data[QUOTA_BITS-1:0];
         end
         if (csr_index == CSR_LIFO_MODE) begin
            lifo_ff <= csr_data[0];
         end
         if (csr_index == CSR_INTERVAL) begin
            interval_ff <= csr_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = {6'd0, rsp_task_ff, rsp_tag_ff, rsp_status_ff};

   `RLRQ_ASSERT_NEVER(a_count_bound, count_ff > CNT_BITS'(QUEUE_DEPTH))
   `RLRQ_ASSERT_IMPLIES(a_pop_nonempty, state_ff == S_POP_OUT, count_ff != '0)
   `RLRQ_ASSERT_NEXT(a_accept_exec, req_tvalid && req_tready, state_ff == S_EXEC)
endmodule
